FILE: sv/pmfk_pkg.sv
// ----------------------------------------------------------------------------
// pmfk_pkg
// Shared types and constants for the distance kernel probability multiplier.
// ----------------------------------------------------------------------------
package pmfk_pkg;

    localparam int MAX_LABELS  = 64;
    // The label field is 6 bits wide, so no more than 64 labels are ever in use.
    localparam int FIELD_LBLS  = 64;
    localparam int USE_LABELS  = (MAX_LABELS < FIELD_LBLS) ? MAX_LABELS : FIELD_LBLS;
    localparam int ADDR_W      = $clog2(MAX_LABELS);
    localparam int CNT_W       = $clog2(USE_LABELS);
    localparam int Q_W         = 16;
    localparam int PROD_W      = 2 * Q_W;
    localparam int ACC_W       = PROD_W + CNT_W;
    localparam int OP_W        = 2;
    localparam int SLOT_W      = 6;
    localparam int LABEL_W     = 6;
    localparam int CNT_CFG_W   = 7;
    localparam logic [CNT_CFG_W-1:0] LABEL_COUNT_RST = CNT_CFG_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_PROB = 2'd0,
        OP_LOAD_KERN = 2'd1,
        OP_MULT      = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_seq_state;

    // Command from the sequencer to the datapath, one per cycle.
    typedef struct packed {
        logic              we_prob;
        logic              we_kern;
        logic [ADDR_W-1:0] waddr;
        logic [Q_W-1:0]    wdata;
        logic              rd_vld;
        logic              rd_first;
        logic              rd_last;
        logic              col_last;
        logic [CNT_W-1:0]  col;
        logic [ADDR_W-1:0] raddr_p;
        logic [ADDR_W-1:0] raddr_k;
    } t_mac_cmd;

    typedef struct packed {
        logic busy;
    } t_mac_stat;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic             col_last;
        logic [CNT_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic               vld;
        logic [LABEL_W-1:0] label;
        logic [Q_W-1:0]     prob_out;
        logic               last;
    } t_result;

endpackage

FILE: sv/pmfk_ifs.sv
// ----------------------------------------------------------------------------
// pmfk_ifs
// Valid/ready channel interfaces for input items, result items and the
// label count register.
// ----------------------------------------------------------------------------
interface pmfk_in_if
    import pmfk_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [Q_W-1:0]    value;

    modport source (output valid, output op, output slot, output value, input ready);
    modport sink   (input valid, input op, input slot, input value, output ready);
endinterface

interface pmfk_out_if
    import pmfk_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] label;
    logic [Q_W-1:0]     prob_out;
    logic               last;

    modport source (output valid, output label, output prob_out, output last, input ready);
    modport sink   (input valid, input label, input prob_out, input last, output ready);
endinterface

interface pmfk_cfg_if
    import pmfk_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CNT_CFG_W-1:0] label_count;

    modport source (output valid, output label_count, input ready);
    modport sink   (input valid, input label_count, output ready);
endinterface

FILE: sv/pmfk_seq.sv
// ----------------------------------------------------------------------------
// pmfk_seq
// Sequencer: takes load and multiply items, and steps the row and column
// counters that drive the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module pmfk_seq
    import pmfk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [OP_W-1:0]      i_in_op,
    input  logic [SLOT_W-1:0]    i_in_slot,
    input  logic [Q_W-1:0]       i_in_value,
    output logic                 o_in_ready,
    input  logic [CNT_CFG_W-1:0] i_label_count,
    input  t_mac_stat            i_stat,
    output t_mac_cmd             o_cmd
);

    t_seq_state       r_state, n_state;
    logic [CNT_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_last_idx, n_last_idx;
    logic [CNT_W-1:0] w_dist;
    logic [CNT_W-1:0] w_count_last;
    logic             w_accept;
    logic             w_slot_ok;

    // Labels in use, minus one: zero counts as one, large values saturate.
    always_comb begin
        if (i_label_count == '0) begin
            w_count_last = '0;
        end else if (32'(i_label_count) > USE_LABELS) begin
            w_count_last = CNT_W'(USE_LABELS - 1);
        end else begin
            w_count_last = CNT_W'(i_label_count - CNT_CFG_W'(1));
        end
    end

    assign w_dist    = (r_row > r_col) ? (r_row - r_col) : (r_col - r_row);
    assign w_accept  = i_in_valid && o_in_ready;
    assign w_slot_ok = (32'(i_in_slot) < MAX_LABELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_last_idx <= n_last_idx;
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_last_idx = r_last_idx;
        o_in_ready = 1'b0;

        o_cmd          = '0;
        o_cmd.waddr    = ADDR_W'(i_in_slot);
        o_cmd.wdata    = i_in_value;
        o_cmd.col      = r_col;
        o_cmd.raddr_p  = ADDR_W'(r_row);
        o_cmd.raddr_k  = ADDR_W'(w_dist);
        o_cmd.rd_first = (r_row == '0);
        o_cmd.rd_last  = (r_row == r_last_idx);
        o_cmd.col_last = (r_col == r_last_idx);

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    case (t_op'(i_in_op))
                        OP_LOAD_PROB: o_cmd.we_prob = w_slot_ok;
                        OP_LOAD_KERN: o_cmd.we_kern = w_slot_ok;
                        OP_MULT: begin
                            n_last_idx = w_count_last;
                            n_row      = '0;
                            n_col      = '0;
                            n_state    = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.rd_vld = 1'b1;
                if (r_row == r_last_idx) begin
                    n_row   = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_row = r_row + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                // Hold off the next column until the current column's sum has left the accumulator.
                if (!i_stat.busy) begin
                    if (r_col == r_last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_col   = r_col + CNT_W'(1);
                        n_state = ST_RUN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: sv/pmfk_mac.sv
// ----------------------------------------------------------------------------
// pmfk_mac
// Datapath: probability and kernel stores, one shared 16x16 multiplier, the
// Q6.32 accumulator, rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module pmfk_mac
    import pmfk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mac_cmd  i_cmd,
    input  logic      i_out_ready,
    output t_mac_stat o_stat,
    output t_result   o_res
);

    logic [Q_W-1:0]    r_prob_mem [MAX_LABELS];
    logic [Q_W-1:0]    r_kern_mem [MAX_LABELS];
    logic [Q_W-1:0]    r_pdata;
    logic [Q_W-1:0]    r_kdata;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_pend_col;
    logic              r_pend_last;
    logic              r_pend;
    t_tag              r_s1, r_s2;
    t_result           r_res;
    logic [ACC_W:0]    w_rnd;
    logic [Q_W-1:0]    w_sat;
    logic              w_take;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we_prob) begin
            r_prob_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.we_kern) begin
            r_kern_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_pdata <= r_prob_mem[i_cmd.raddr_p];
        r_kdata <= r_kern_mem[i_cmd.raddr_k];
    end

    // Round half up to Q0.16, then saturate.
    assign w_rnd  = {1'b0, r_acc} + (ACC_W + 1)'(32768);
    assign w_sat  = (w_rnd[ACC_W:PROD_W] != '0) ? '1 : w_rnd[PROD_W-1:Q_W];
    assign w_take = r_pend && (!r_res.vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld  <= 1'b0;
            r_s2.vld  <= 1'b0;
            r_pend    <= 1'b0;
            r_res.vld <= 1'b0;
        end else begin
            r_s1.vld <= i_cmd.rd_vld;
            r_s2.vld <= r_s1.vld;
            if (r_s2.vld && r_s2.last) begin
                r_pend <= 1'b1;
            end else if (w_take) begin
                r_pend <= 1'b0;
            end
            if (w_take) begin
                r_res.vld <= 1'b1;
            end else if (i_out_ready) begin
                r_res.vld <= 1'b0;
            end
        end
        r_s1.first    <= i_cmd.rd_first;
        r_s1.last     <= i_cmd.rd_last;
        r_s1.col_last <= i_cmd.col_last;
        r_s1.col      <= i_cmd.col;
        r_s2.first    <= r_s1.first;
        r_s2.last     <= r_s1.last;
        r_s2.col_last <= r_s1.col_last;
        r_s2.col      <= r_s1.col;
        r_prod        <= r_pdata * r_kdata;
        if (r_s2.vld) begin
            r_acc <= (r_s2.first ? '0 : r_acc) + ACC_W'(r_prod);
            if (r_s2.last) begin
                r_pend_col  <= r_s2.col;
                r_pend_last <= r_s2.col_last;
            end
        end
        if (w_take) begin
            r_res.label    <= LABEL_W'(r_pend_col);
            r_res.prob_out <= w_sat;
            r_res.last     <= r_pend_last;
        end
    end

    assign o_stat.busy = r_s1.vld || r_s2.vld || r_pend;
    assign o_res       = r_res;

endmodule

FILE: sv/pmf_distance_kernel_multiply.sv
// ----------------------------------------------------------------------------
// pmf_distance_kernel_multiply
// Multiplies a label probability vector by a distance kernel table:
// out[c] = sum over r of prob[r] * kernel[|r - c|], Q0.16 in and out.
//
//   channel  dir  handshake     payload
//   i_in     in   valid/ready   op, slot, value
//   o_out    out  valid/ready   label, prob_out, last
//   i_cfg    in   valid/ready   label_count
//
// A load item is written into its store when it is accepted. A multiply item
// over N labels computes one product per cycle while a column runs, through
// the single shared multiplier and the single read port of each store, with
// a drain of the pipeline at the end of every column. Input ready is low
// for the whole run. A full result register holds the sequencer at the end
// of a column until the column's sum can move into it.
// Reset is synchronous and active low; the stores are not cleared.
// ----------------------------------------------------------------------------
module pmf_distance_kernel_multiply
    import pmfk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pmfk_in_if.sink    i_in,
    pmfk_out_if.source o_out,
    pmfk_cfg_if.sink   i_cfg
);

    logic [CNT_CFG_W-1:0] r_label_count;
    t_mac_cmd             w_cmd;
    t_mac_stat            w_stat;
    t_result              w_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_count <= LABEL_COUNT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_label_count <= i_cfg.label_count;
        end
    end

    pmfk_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_op       (i_in.op),
        .i_in_slot     (i_in.slot),
        .i_in_value    (i_in.value),
        .o_in_ready    (i_in.ready),
        .i_label_count (r_label_count),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    pmfk_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_out_ready (o_out.ready),
        .o_stat      (w_stat),
        .o_res       (w_res)
    );

    assign o_out.valid    = w_res.vld;
    assign o_out.label    = w_res.label;
    assign o_out.prob_out = w_res.prob_out;
    assign o_out.last     = w_res.last;

    // A new item is only taken once the datapath has fully drained.
    a_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !w_stat.busy)
        else $error("item accepted while the datapath is busy");

    // A multiply closes the input until its run is done.
    a_mult_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.op == OP_MULT) |=> !i_in.ready)
        else $error("input still ready after a multiply item");

    // Store writes happen only for accepted load items.
    a_write_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.we_prob || w_cmd.we_kern) |-> (i_in.valid && i_in.ready && !w_cmd.rd_vld))
        else $error("store written outside a load item");

endmodule
